// File: hw/rtl/extended_gcd_bezout_assert.svh
// Assertion macros used by the top-level RTL of the extended GCD block.
// Each macro takes a label, an antecedent, a consequent and a message.
// They sample on clk and are disabled while rst_n is low.
`ifndef EXTENDED_GCD_BEZOUT_ASSERT_SVH
`define EXTENDED_GCD_BEZOUT_ASSERT_SVH

`ifndef SYNTH
`define EGCD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define EGCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EGCD_ASSERT_SAME(label, ante, cons, msg)
`define EGCD_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// File: hw/rtl/egcd_pkg.sv
`default_nettype none

package egcd_pkg;

  // Result field widths
  localparam int unsigned DW = 31;
  localparam int unsigned CW = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_DOWN,
    ST_MUL_M,
    ST_MUL_N,
    ST_UPDATE
  } egcd_state_t;

  // Commands to the shift-subtract divider
  typedef struct packed {
    logic load;
    logic up;
    logic down;
  } div_ctrl_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic grow;
    logic last;
    logic rem_zero;
  } div_stat_t;

endpackage

`default_nettype wire

// File: hw/rtl/egcd_div.sv
`default_nettype none

module egcd_div #(
  parameter int unsigned WIDTH = 31
) (
  input  wire logic                clk,
  input  wire egcd_pkg::div_ctrl_t ctrl,
  input  wire logic [WIDTH-1:0]    dividend,
  input  wire logic [WIDTH-1:0]    divisor,
  output egcd_pkg::div_stat_t      stat,
  output logic      [WIDTH-1:0]    quot,
  output logic      [WIDTH-1:0]    rem
);
  import egcd_pkg::*;

  localparam int unsigned KW = $clog2(WIDTH);

  logic [WIDTH-1:0] r_r, r_nxt;
  logic [WIDTH-1:0] d_r, d_nxt;
  logic [WIDTH-1:0] q_r, q_nxt;
  logic [KW-1:0]    k_r, k_nxt;
  logic             ge;
  logic [WIDTH-1:0] rem_after;

  assign ge        = d_r <= r_r;
  assign rem_after = ge ? (r_r - d_r) : r_r;

  always_comb begin
    stat.grow     = {d_r, 1'b0} <= {1'b0, r_r};
    stat.last     = k_r == '0;
    stat.rem_zero = rem_after == '0;
  end

  always_comb begin
    r_nxt = r_r;
    d_nxt = d_r;
    q_nxt = q_r;
    k_nxt = k_r;
    if (ctrl.load) begin
      r_nxt = dividend;
      d_nxt = divisor;
      q_nxt = '0;
      k_nxt = '0;
    end else if (ctrl.up) begin
      // align divisor under the dividend's top bit
      d_nxt = {d_r[WIDTH-2:0], 1'b0};
      k_nxt = k_r + KW'(1);
    end else if (ctrl.down) begin
      r_nxt = rem_after;
      q_nxt = {q_r[WIDTH-2:0], ge};
      if (k_r != '0) begin
        d_nxt = d_r >> 1;
        k_nxt = k_r - KW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    d_r <= d_nxt;
    q_r <= q_nxt;
    k_r <= k_nxt;
  end

  assign quot = q_r;
  assign rem  = r_r;

endmodule

`default_nettype wire

// File: hw/rtl/extended_gcd_bezout.sv
`default_nettype none

// Extended Euclid: takes two positive operands on a start pulse and, once
// done, strobes out_valid for exactly one cycle with the gcd and the
// Bezout pair (coeff_larger, coeff_smaller) such that
// gcd = coeff_larger*larger + coeff_smaller*smaller, with the coefficients in
// 32-bit two's complement. On equal operands operand_b counts as the larger.
// The receiver cannot stall: capture the result beat in the strobe cycle,
// since it is not held for you. busy stays high from the accepting edge until
// the strobe; start is ignored while busy. The work is done by one restoring
// shift-subtract divider and one 32x32 multiplier, reused for every Euclid
// step: the divider shifts the divisor up under the dividend, then back down,
// taking one quotient bit at each position, and ST_MUL_M, ST_MUL_N and
// ST_UPDATE then update the coefficients (the last step skips the update).
// Consecutive Fibonacci operands give the longest Euclid chains; a zero smaller
// operand returns in the cycle after acceptance, without raising busy.
module extended_gcd_bezout #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic [OPERAND_BITS-1:0]        in_operand_a,
  input  wire logic [OPERAND_BITS-1:0]        in_operand_b,
  output logic                                out_valid,
  output logic        [egcd_pkg::DW-1:0]      out_divisor,
  output logic signed [egcd_pkg::CW-1:0]      out_coeff_larger,
  output logic signed [egcd_pkg::CW-1:0]      out_coeff_smaller,
  output logic                                out_a_is_larger
);
  import egcd_pkg::*;

  `include "extended_gcd_bezout_assert.svh"

  localparam int unsigned W = OPERAND_BITS;

  egcd_state_t state_r, state_nxt;

  // Euclid working set: rc is the current divisor, mp/np and mc/nc the
  // coefficients of the previous and current remainder
  logic [W-1:0]  rc_r, rc_nxt;
  logic [CW-1:0] mp_r, mp_nxt;
  logic [CW-1:0] np_r, np_nxt;
  logic [CW-1:0] mc_r, mc_nxt;
  logic [CW-1:0] nc_r, nc_nxt;
  logic [CW-1:0] mn_r, mn_nxt;
  logic [CW-1:0] prod_r, prod_nxt;

  logic          valid_r, valid_nxt;
  logic [DW-1:0] div_out_r, div_out_nxt;
  logic [CW-1:0] m_out_r, m_out_nxt;
  logic [CW-1:0] n_out_r, n_out_nxt;
  logic          a_big_r, a_big_nxt;

  logic          a_big;
  logic [W-1:0]  larger;
  logic [W-1:0]  smaller;

  div_ctrl_t     div_ctrl;
  div_stat_t     div_stat;
  logic [W-1:0]  div_dividend;
  logic [W-1:0]  div_divisor;
  logic [W-1:0]  div_quot;
  logic [W-1:0]  div_rem;

  logic [CW-1:0] mul_a;
  logic [CW-1:0] mul_b;
  logic [CW-1:0] mul_full;

  // Order the operands; a tie leaves operand_b as the larger
  assign a_big   = in_operand_a > in_operand_b;
  assign larger  = a_big ? in_operand_a : in_operand_b;
  assign smaller = a_big ? in_operand_b : in_operand_a;

  // Shared multiplier: quotient times mc, then quotient times nc. Keep the
  // low half only, since the coefficients wrap at 32 bits.
  assign mul_a    = CW'(div_quot);
  assign mul_b    = (state_r == ST_MUL_M) ? mc_r : nc_r;
  assign mul_full = mul_a * mul_b;

  egcd_div #(
    .WIDTH (W)
  ) u_div (
    .clk      (clk),
    .ctrl     (div_ctrl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && (smaller != '0)) begin
          state_nxt = ST_UP;
        end
      end
      ST_UP: begin
        if (!div_stat.grow) begin
          state_nxt = ST_DOWN;
        end
      end
      ST_DOWN: begin
        if (div_stat.last) begin
          state_nxt = div_stat.rem_zero ? ST_IDLE : ST_MUL_M;
        end
      end
      ST_MUL_M:  state_nxt = ST_MUL_N;
      ST_MUL_N:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_UP;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: divider commands and operand selection
  always_comb begin
    busy          = state_r != ST_IDLE;
    div_ctrl.load = ((state_r == ST_IDLE) && start && (smaller != '0)) ||
                    (state_r == ST_UPDATE);
    div_ctrl.up   = (state_r == ST_UP) && div_stat.grow;
    div_ctrl.down = state_r == ST_DOWN;
    div_dividend  = (state_r == ST_IDLE) ? larger : rc_r;
    div_divisor   = (state_r == ST_IDLE) ? smaller : div_rem;
  end

  // Datapath
  always_comb begin
    rc_nxt      = rc_r;
    mp_nxt      = mp_r;
    np_nxt      = np_r;
    mc_nxt      = mc_r;
    nc_nxt      = nc_r;
    mn_nxt      = mn_r;
    prod_nxt    = prod_r;
    valid_nxt   = 1'b0;
    div_out_nxt = div_out_r;
    m_out_nxt   = m_out_r;
    n_out_nxt   = n_out_r;
    a_big_nxt   = a_big_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          rc_nxt    = smaller;
          mp_nxt    = CW'(1);
          np_nxt    = '0;
          mc_nxt    = '0;
          nc_nxt    = CW'(1);
          a_big_nxt = a_big;
          // smaller operand zero: gcd is the larger one, trivially
          if (smaller == '0) begin
            valid_nxt   = 1'b1;
            div_out_nxt = DW'(larger);
            m_out_nxt   = CW'(1);
            n_out_nxt   = '0;
          end
        end
      end
      ST_DOWN: begin
        // remainder zero after this division: rc is the gcd
        if (div_stat.last && div_stat.rem_zero) begin
          valid_nxt   = 1'b1;
          div_out_nxt = DW'(rc_r);
          m_out_nxt   = mc_r;
          n_out_nxt   = nc_r;
        end
      end
      ST_MUL_M: begin
        prod_nxt = mul_full[CW-1:0];
      end
      ST_MUL_N: begin
        mn_nxt   = mp_r - prod_r;
        prod_nxt = mul_full[CW-1:0];
      end
      ST_UPDATE: begin
        // advance the remainder sequence by one step
        rc_nxt = div_rem;
        mp_nxt = mc_r;
        mc_nxt = mn_r;
        np_nxt = nc_r;
        nc_nxt = np_r - prod_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rc_r      <= rc_nxt;
    mp_r      <= mp_nxt;
    np_r      <= np_nxt;
    mc_r      <= mc_nxt;
    nc_r      <= nc_nxt;
    mn_r      <= mn_nxt;
    prod_r    <= prod_nxt;
    div_out_r <= div_out_nxt;
    m_out_r   <= m_out_nxt;
    n_out_r   <= n_out_nxt;
    a_big_r   <= a_big_nxt;
  end

  assign out_valid         = valid_r;
  assign out_divisor       = div_out_r;
  assign out_coeff_larger  = m_out_r;
  assign out_coeff_smaller = n_out_r;
  assign out_a_is_larger   = a_big_r;

  `EGCD_ASSERT_SAME(a_strobe_idle, valid_r, !busy, "result strobed while still busy")
  `EGCD_ASSERT_NEXT(a_start_runs, (!busy && start && (smaller != '0)), (state_r == ST_UP),
                    "accepted item did not start a division")
  `EGCD_ASSERT_NEXT(a_mul_order, (state_r == ST_MUL_M), (state_r == ST_MUL_N),
                    "coefficient multiply sequence broken")
  `EGCD_ASSERT_SAME(a_update_rem, (state_r == ST_UPDATE), (div_rem != '0),
                    "update with zero remainder")

endmodule

`default_nettype wire

// File: bench/tb_extended_gcd_bezout.sv
`default_nettype none

// Self-checking bench for the extended Euclid block.
//
// Every accepted operand beat is run through a local predictor of the GCD and
// the Bezout pair. The prediction is queued, and each strobed result beat is
// compared field by field with the oldest prediction. The block keeps no
// state between items, so the run is a sequence of directed checks followed
// by three random phases. In the first phase the sender idles often, in the
// second it idles most of the time, and in the third it never idles. The
// receiver cannot stall, so only the sender ever holds off.
module tb_extended_gcd_bezout;

  localparam int unsigned OPERAND_BITS = 31;
  localparam int unsigned DW = egcd_pkg::DW;
  localparam int unsigned CW = egcd_pkg::CW;

  localparam logic [OPERAND_BITS-1:0] OPERAND_MAX = '1;

  // The limit covers the longest 31-bit Euclid run, with generous
  // headroom on top of that for the longest sender gap.
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned ITEMS_PER_PHASE = 450;

  typedef struct packed {
    logic        [DW-1:0] divisor;
    logic signed [CW-1:0] coeff_larger;
    logic signed [CW-1:0] coeff_smaller;
    logic                 a_is_larger;
  } bezout_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [OPERAND_BITS-1:0] in_operand_a = '0;
  logic [OPERAND_BITS-1:0] in_operand_b = '0;
  logic                    out_valid;
  logic        [DW-1:0]    out_divisor;
  logic signed [CW-1:0]    out_coeff_larger;
  logic signed [CW-1:0]    out_coeff_smaller;
  logic                    out_a_is_larger;

  bezout_t     pending_bezout_q[$];
  int unsigned error_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_cycles = 0;

  extended_gcd_bezout #(
    .OPERAND_BITS(OPERAND_BITS)
  ) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operand_a     (in_operand_a),
    .in_operand_b     (in_operand_b),
    .out_valid        (out_valid),
    .out_divisor      (out_divisor),
    .out_coeff_larger (out_coeff_larger),
    .out_coeff_smaller(out_coeff_smaller),
    .out_a_is_larger  (out_a_is_larger)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Order the operands and run plain extended Euclid on them. Keep the
  // coefficients in 64-bit wrapping arithmetic and truncate them on output.
  // operand_b counts as the larger when the two are equal. A zero smaller
  // operand returns the larger one with the pair (1, 0).
  function automatic bezout_t predict_bezout(input logic [OPERAND_BITS-1:0] a,
                                             input logic [OPERAND_BITS-1:0] b);
    bezout_t     res;
    logic [63:0] r_prev;
    logic [63:0] r_cur;
    logic [63:0] m_prev;
    logic [63:0] n_prev;
    logic [63:0] m_cur;
    logic [63:0] n_cur;
    logic [63:0] quot;
    logic [63:0] r_next;
    logic [63:0] m_next;
    logic [63:0] n_next;
    logic        a_big;
    a_big  = (a > b);
    r_prev = a_big ? 64'(a) : 64'(b);
    r_cur  = a_big ? 64'(b) : 64'(a);
    m_prev = 64'd1;
    n_prev = 64'd0;
    m_cur  = 64'd0;
    n_cur  = 64'd1;
    if (r_cur == 64'd0) begin
      m_cur = 64'd1;
      n_cur = 64'd0;
      r_cur = r_prev;
    end else begin
      while ((r_prev % r_cur) != 64'd0) begin
        quot   = r_prev / r_cur;
        r_next = r_prev - quot * r_cur;
        m_next = m_prev - quot * m_cur;
        n_next = n_prev - quot * n_cur;
        r_prev = r_cur;
        m_prev = m_cur;
        n_prev = n_cur;
        r_cur  = r_next;
        m_cur  = m_next;
        n_cur  = n_next;
      end
    end
    res.divisor       = r_cur[DW-1:0];
    res.coeff_larger  = m_cur[CW-1:0];
    res.coeff_smaller = n_cur[CW-1:0];
    res.a_is_larger   = a_big;
    return res;
  endfunction

  function automatic logic [OPERAND_BITS-1:0] fibonacci(input int unsigned k);
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] nxt;
    lo = 64'd0;
    hi = 64'd1;
    repeat (k) begin
      nxt = lo + hi;
      lo  = hi;
      hi  = nxt;
    end
    return lo[OPERAND_BITS-1:0];
  endfunction

  // Drive one operand beat and hold it until the block takes it. Decide on
  // any gap at the falling edge first, so start sees one assignment per step.
  task automatic send_operands(input logic [OPERAND_BITS-1:0] a,
                               input logic [OPERAND_BITS-1:0] b);
    @(negedge clk);
    // Short coin-flip gaps, plus an occasional long pause so that some gaps
    // outlast the busy window and land with the block idle.
    if (idle_pct != 0 && $urandom_range(399) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < 97) begin
        @(negedge clk);
      end
    end
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    pending_bezout_q.push_back(predict_bezout(a, b));
  endtask

  // Random operand of random significant width, never zero.
  function automatic logic [OPERAND_BITS-1:0] random_operand();
    int unsigned width;
    logic [31:0] val;
    width = $urandom_range(OPERAND_BITS, 1);
    val   = $urandom & ((32'd1 << width) - 32'd1);
    if (val == 32'd0) begin
      val = 32'd1;
    end
    return val[OPERAND_BITS-1:0];
  endfunction

  task automatic test_equal_operands();
    send_operands(OPERAND_BITS'(1), OPERAND_BITS'(1));
    send_operands(OPERAND_MAX, OPERAND_MAX);
    send_operands(31'h5555_5555, 31'h5555_5555);
  endtask

  task automatic test_extreme_operands();
    send_operands(OPERAND_BITS'(1), OPERAND_MAX);
    send_operands(OPERAND_MAX, OPERAND_BITS'(1));
    send_operands(OPERAND_MAX, OPERAND_MAX - OPERAND_BITS'(1));
    send_operands(OPERAND_MAX - OPERAND_BITS'(1), OPERAND_MAX);
    send_operands(OPERAND_MAX, OPERAND_BITS'(2));
    send_operands(31'h5555_5555, 31'h2AAA_AAAA);
    send_operands(31'h4000_0000, 31'h3000_0000);
  endtask

  // Smaller divides larger: the pair must come back as (0, 1).
  task automatic test_divisible_operands();
    send_operands(OPERAND_BITS'(12), OPERAND_BITS'(4));
    send_operands(OPERAND_BITS'(4), OPERAND_BITS'(12));
    send_operands(31'h4000_0000, 31'h0000_8000);
    send_operands(OPERAND_BITS'(3), 31'h7FFF_FFFE);
  endtask

  // Out of range, but the block defines it: gcd(L, 0) = L with the pair (1, 0).
  task automatic test_zero_operands();
    send_operands('0, OPERAND_BITS'(5));
    send_operands(OPERAND_MAX, '0);
    send_operands('0, '0);
  endtask

  // Consecutive Fibonacci numbers give the longest Euclid chains.
  task automatic test_fibonacci_chain();
    send_operands(fibonacci(46), fibonacci(45));
    send_operands(fibonacci(45), fibonacci(46));
    send_operands(fibonacci(20), fibonacci(19));
  endtask

  task automatic test_random_operands(input int unsigned n_items, input int unsigned pct);
    logic [OPERAND_BITS-1:0] a;
    logic [OPERAND_BITS-1:0] b;
    logic [OPERAND_BITS-1:0] tmp;
    logic [63:0]             scaled;
    int unsigned             g;
    int unsigned             k;
    idle_pct = pct;
    repeat (n_items) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          a = OPERAND_BITS'($urandom);
          b = OPERAND_BITS'($urandom);
        end
        3, 4: begin
          a = random_operand();
          b = random_operand();
        end
        5: begin
          // Shared factor, so the gcd is a multiple of it.
          g = $urandom_range(4096, 1);
          a = OPERAND_BITS'($urandom_range(32'h7FFF_FFFF / g, 1) * g);
          b = OPERAND_BITS'($urandom_range(32'h7FFF_FFFF / g, 1) * g);
        end
        6: begin
          a      = random_operand();
          k      = $urandom_range(32'h7FFF_FFFF / a, 1);
          scaled = 64'(a) * 64'(k);
          b      = scaled[OPERAND_BITS-1:0];
        end
        7: begin
          a = OPERAND_BITS'($urandom);
          if (a == '0) begin
            a = OPERAND_BITS'(1);
          end
          b = a;
        end
        8: begin
          a = $urandom_range(1) ? OPERAND_MAX : OPERAND_BITS'(1);
          b = OPERAND_BITS'($urandom);
          if (b == '0) begin
            b = OPERAND_BITS'(1);
          end
        end
        default: begin
          k = $urandom_range(45, 2);
          a = fibonacci(k + 1);
          b = fibonacci(k);
        end
      endcase
      if (a == '0) begin
        a = OPERAND_BITS'(1);
      end
      if (b == '0) begin
        b = OPERAND_BITS'(1);
      end
      if ($urandom_range(1)) begin
        tmp = a;
        a   = b;
        b   = tmp;
      end
      send_operands(a, b);
    end
  endtask

  // Compare every strobed result beat with the oldest prediction.
  always @(posedge clk) begin
    bezout_t exp_res;
    if (rst_n && out_valid) begin
      if (pending_bezout_q.size() == 0) begin
        error_count++;
        $error("divisor: result beat with no prediction waiting, actual %0d", out_divisor);
      end else begin
        exp_res = pending_bezout_q.pop_front();
        if (out_divisor !== exp_res.divisor) begin
          error_count++;
          $error("divisor: expected %0d, actual %0d", exp_res.divisor, out_divisor);
        end
        if (out_coeff_larger !== exp_res.coeff_larger) begin
          error_count++;
          $error("coeff_larger: expected %0d, actual %0d",
                 exp_res.coeff_larger, out_coeff_larger);
        end
        if (out_coeff_smaller !== exp_res.coeff_smaller) begin
          error_count++;
          $error("coeff_smaller: expected %0d, actual %0d",
                 exp_res.coeff_smaller, out_coeff_smaller);
        end
        if (out_a_is_larger !== exp_res.a_is_larger) begin
          error_count++;
          $error("a_is_larger: expected %0d, actual %0d",
                 exp_res.a_is_larger, out_a_is_larger);
        end
      end
    end
  end

  // Count cycles in which no beat moves on either side. Give up once the
  // count reaches the limit.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    idle_pct = 35;
    test_equal_operands();
    test_extreme_operands();
    test_divisible_operands();
    test_zero_operands();
    test_fibonacci_chain();

    test_random_operands(ITEMS_PER_PHASE, 35);
    test_random_operands(ITEMS_PER_PHASE, 73);
    test_random_operands(ITEMS_PER_PHASE, 0);

    // Drop start, wait for the last result beat, then watch for strays.
    @(negedge clk);
    start <= 1'b0;
    while (pending_bezout_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (pending_bezout_q.size() != 0) begin
      error_count++;
      $error("divisor: %0d predictions left without a result beat",
             pending_bezout_q.size());
    end
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
